@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Every form is clocked on the rising edge
// and held off while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The expression must hold on every clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)

`endif

`endif

@@ src/isingmp_pkg.sv @@
// ----------------------------------------------------------------------------
// isingmp_pkg
// Types, constants and the exponential lookup table of the Ising Metropolis
// spin-flip engine.
// ----------------------------------------------------------------------------
`default_nettype none

package isingmp_pkg;

  // Sizes of the spin system and of the fixed-point data.
  localparam int unsigned MAX_SPINS       = 64;
  localparam int unsigned SITE_W          = $clog2(MAX_SPINS);
  localparam int unsigned COEF_BITS       = 16;
  localparam int unsigned CNT_W           = 7;
  localparam logic [CNT_W-1:0] CNT_RESET  = CNT_W'(MAX_SPINS);
  localparam int unsigned CPL_ADDR_W      = 2 * SITE_W;
  // Field plus up to MAX_SPINS - 1 couplings, with one sign bit of headroom.
  localparam int unsigned ACC_W           = COEF_BITS + SITE_W + 1;
  localparam int unsigned DE_W            = 24;

  // Exponential table: entry k is about 65536 * exp(-k/64).
  localparam int unsigned EXP_TABLE_DEPTH = 1024;
  localparam int unsigned EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned EXP_VAL_W       = 17;
  localparam logic [63:0] EXP_STEP_MUL    = 64'd4228380000;

  // Configuration port.
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = CNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPIN_COUNT = 1'b0,
    CFG_SYSTEMATIC = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_LOAD_FIELD    = 3'd0,
    OP_LOAD_COUPLING = 3'd1,
    OP_SET_SPIN      = 3'd2,
    OP_STEP          = 3'd3,
    OP_READ_SPIN     = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]               opcode;
    logic [SITE_W-1:0]        site_index;
    logic [SITE_W-1:0]        partner_index;
    logic signed [15:0]       coefficient;
    logic [15:0]              uniform_draw;
  } in_item_t;

  typedef struct packed {
    logic [SITE_W-1:0]        site;
    logic                     spin_up;
    logic                     accepted;
    logic signed [DE_W-1:0]   energy_change;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COUPLE2,
    ST_STEP_START,
    ST_STEP_SUM,
    ST_STEP_DRAIN,
    ST_STEP_DE,
    ST_STEP_EXP,
    ST_STEP_DECIDE,
    ST_RESULT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // an input item is taken this cycle
    logic couple2;     // mirrored coupling write
    logic step_start;  // read the field and clear the accumulator
    logic sum_issue;   // read one coupling of the row
    logic de_calc;     // form the energy change
    logic exp_read;    // look up the exponential table
    logic decide;      // acceptance test and spin write-back
    logic load_out;    // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sum_last;    // the last coupling of the row is being read
  } dp_sts_t;

  typedef logic [EXP_VAL_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  // Builds the exponential table by repeated fixed-point multiplication.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] t;
    t = 64'h1_0000_0000;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      rom[k] = EXP_VAL_W'((t + 64'h8000) >> 16);
      t = (t * EXP_STEP_MUL + 64'h8000_0000) >> 32;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

@@ src/ising_metropolis_spin_flip.sv @@
// ----------------------------------------------------------------------------
// ising_metropolis_spin_flip
// Ising spin engine with Metropolis single-spin updates, loaded and stepped by
// items; one result item per input item.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_stall_o   in_data_i  (isingmp_pkg::in_item_t)
//   out      output     out_valid_o/out_stall_i out_data_o (isingmp_pkg::out_item_t)
//   cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// A load, set or read item passes through the result state, a coupling load
// first through the mirrored write and a Metropolis step first through the
// start, sum, drain, energy, lookup and decide states; the step's length is set by
// the coupling memory port, which delivers one coupling of the row per cycle.
// Reset clears the spin vector and the sweep counter and sets the configuration
// to 64 spins in use with the site taken from the item; field and coupling
// memories hold no reset value.
// A new item is taken while a finished result waits in the output register;
// that next item then waits in its result state until the register drains.

`default_nettype none

`include "assert_macros.svh"

module ising_metropolis_spin_flip (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire isingmp_pkg::in_item_t              in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output isingmp_pkg::out_item_t                  out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [isingmp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [isingmp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  isingmp_pkg::dp_cmd_t cmd;
  isingmp_pkg::dp_sts_t sts;

  // Sequencer.
  isingmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_opcode_i (in_data_i.opcode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Storage and arithmetic.
  isingmp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

  // Only one phase of the sequence is active in any cycle.
  `ASSERT_ALWAYS(a_one_cmd, clk_i, rst_ni, $onehot0(cmd), "more than one datapath command")

  // An accepted item keeps the input stalled in the following cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after accept")

  // A result is never loaded over one that is still stalled.
  `ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, cmd.load_out, !(out_valid_o && out_stall_i), "result overwritten")

  // A loaded result is presented in the next cycle.
  `ASSERT_NEXT(a_load_shows, clk_i, rst_ni, cmd.load_out, out_valid_o, "loaded result not valid")

endmodule

`default_nettype wire

@@ src/isingmp_ctrl.sv @@
// ----------------------------------------------------------------------------
// isingmp_ctrl
// Controller of the spin-flip engine: sequences loads, Metropolis steps and
// the hand-over of each result into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module isingmp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [2:0]           in_opcode_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output isingmp_pkg::dp_cmd_t      cmd_o,
  input  wire isingmp_pkg::dp_sts_t sts_i
);

  isingmp_pkg::state_e state_q, state_d;
  logic                out_vld_q, out_vld_d;
  logic                out_free;

  // An item is taken only when the engine is idle.
  assign in_stall_o  = (state_q != isingmp_pkg::ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_free    = !out_vld_q || !out_stall_i;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      isingmp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_opcode_i == isingmp_pkg::OP_LOAD_COUPLING) begin
            state_d = isingmp_pkg::ST_COUPLE2;
          end else if (in_opcode_i == isingmp_pkg::OP_STEP) begin
            state_d = isingmp_pkg::ST_STEP_START;
          end else begin
            state_d = isingmp_pkg::ST_RESULT;
          end
        end
      end
      isingmp_pkg::ST_COUPLE2:     state_d = isingmp_pkg::ST_RESULT;
      isingmp_pkg::ST_STEP_START:  state_d = isingmp_pkg::ST_STEP_SUM;
      isingmp_pkg::ST_STEP_SUM: begin
        if (sts_i.sum_last) begin
          state_d = isingmp_pkg::ST_STEP_DRAIN;
        end
      end
      isingmp_pkg::ST_STEP_DRAIN:  state_d = isingmp_pkg::ST_STEP_DE;
      isingmp_pkg::ST_STEP_DE:     state_d = isingmp_pkg::ST_STEP_EXP;
      isingmp_pkg::ST_STEP_EXP:    state_d = isingmp_pkg::ST_STEP_DECIDE;
      isingmp_pkg::ST_STEP_DECIDE: state_d = isingmp_pkg::ST_RESULT;
      isingmp_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = isingmp_pkg::ST_IDLE;
        end
      end
      default:                     state_d = isingmp_pkg::ST_IDLE;
    endcase
  end

  // Command outputs, one group per state.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      isingmp_pkg::ST_IDLE:        cmd_o.capture    = in_valid_i;
      isingmp_pkg::ST_COUPLE2:     cmd_o.couple2    = 1'b1;
      isingmp_pkg::ST_STEP_START:  cmd_o.step_start = 1'b1;
      isingmp_pkg::ST_STEP_SUM:    cmd_o.sum_issue  = 1'b1;
      isingmp_pkg::ST_STEP_DRAIN:  cmd_o           = '0;
      isingmp_pkg::ST_STEP_DE:     cmd_o.de_calc    = 1'b1;
      isingmp_pkg::ST_STEP_EXP:    cmd_o.exp_read   = 1'b1;
      isingmp_pkg::ST_STEP_DECIDE: cmd_o.decide     = 1'b1;
      isingmp_pkg::ST_RESULT:      cmd_o.load_out   = out_free;
      default:                     cmd_o           = '0;
    endcase
  end

  // The output valid is set on a load and cleared when the item is taken.
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= isingmp_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

`default_nettype wire

@@ src/isingmp_dp.sv @@
// ----------------------------------------------------------------------------
// isingmp_dp
// Datapath of the spin-flip engine: spin vector, field and coupling memories,
// the energy accumulator, the exponential lookup and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module isingmp_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire isingmp_pkg::dp_cmd_t                 cmd_i,
  output isingmp_pkg::dp_sts_t                      sts_o,
  input  wire isingmp_pkg::in_item_t                in_data_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [isingmp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [isingmp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output isingmp_pkg::out_item_t                    out_data_o
);

  localparam int unsigned SiteW = isingmp_pkg::SITE_W;
  localparam int unsigned CntW  = isingmp_pkg::CNT_W;
  localparam int unsigned AccW  = isingmp_pkg::ACC_W;
  localparam int unsigned DeW   = isingmp_pkg::DE_W;
  localparam int unsigned ExpW  = isingmp_pkg::EXP_IDX_W;

  // Configuration and control state.
  logic [CntW-1:0]                    spin_cnt_q;
  logic                               sys_mode_q;
  logic [SiteW-1:0]                   sweep_q, sweep_d;
  logic [isingmp_pkg::MAX_SPINS-1:0]  spin_q;
  logic [SiteW-1:0]                   idx_q;
  logic [SiteW-1:0]                   rd_idx_q;
  logic                               rd_vld_q;
  logic                               fld_vld_q;

  // Item and working registers.
  logic [SiteW-1:0]                   site_q;
  logic [SiteW-1:0]                   partner_q;
  logic signed [15:0]                 coef_q;
  logic [15:0]                        draw_q;
  logic signed [AccW-1:0]             acc_q, acc_d;
  logic signed [DeW-1:0]              de_q;
  logic [isingmp_pkg::EXP_VAL_W-1:0]  exp_q;
  logic                               acc_flag_q;
  logic signed [DeW-1:0]              de_res_q;
  isingmp_pkg::out_item_t             out_q;

  // Memories.
  logic signed [15:0] field_mem [isingmp_pkg::MAX_SPINS];
  logic signed [15:0] coup_mem  [2**isingmp_pkg::CPL_ADDR_W];
  logic signed [15:0] field_rd_q;
  logic signed [15:0] coup_rd_q;

  logic [CntW-1:0]                    n_act;
  logic [SiteW-1:0]                   cur_site;
  logic [CntW-1:0]                    cur_inc;
  logic                               cap_step;
  logic                               coup_we;
  logic [isingmp_pkg::CPL_ADDR_W-1:0] coup_waddr;
  logic signed [15:0]                 coup_wdata;
  logic                               field_we;
  logic                               new_spin;
  logic signed [AccW-1:0]             term;
  logic signed [AccW-1:0]             fld_ext;
  logic signed [DeW-1:0]              acc2;
  logic                               de_pos;
  logic                               keep;
  logic                               in_range;

  // Active spin count: zero acts as one, values above the maximum clamp.
  always_comb begin
    if (spin_cnt_q == '0) begin
      n_act = CntW'(1);
    end else if (spin_cnt_q > CntW'(isingmp_pkg::MAX_SPINS)) begin
      n_act = CntW'(isingmp_pkg::MAX_SPINS);
    end else begin
      n_act = spin_cnt_q;
    end
  end

  // Sweep counter: current site and its wrapped successor.
  assign cur_site = ({1'b0, sweep_q} < n_act) ? sweep_q : '0;
  assign cur_inc  = {1'b0, cur_site} + CntW'(1);
  assign sweep_d  = (cur_inc >= n_act) ? '0 : cur_inc[SiteW-1:0];
  assign cap_step = cmd_i.capture && (in_data_i.opcode == isingmp_pkg::OP_STEP);

  assign sts_o.sum_last = ({1'b0, idx_q} == (n_act - CntW'(1)));

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spin_cnt_q <= isingmp_pkg::CNT_RESET;
      sys_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        isingmp_pkg::CFG_SPIN_COUNT: spin_cnt_q <= cfg_data_i;
        isingmp_pkg::CFG_SYSTEMATIC: sys_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Acceptance test on the looked-up exponential.
  assign de_pos   = !de_q[DeW-1] && (de_q != '0);
  assign keep     = !de_pos || ({1'b0, draw_q} <= exp_q);
  assign in_range = ({1'b0, site_q} < n_act);
  assign new_spin = !spin_q[site_q];

  // Control state: sweep counter, spin vector and read sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q   <= '0;
      spin_q    <= '0;
      idx_q     <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      fld_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.sum_issue;
      rd_idx_q  <= idx_q;
      fld_vld_q <= cmd_i.step_start;
      if (cap_step) begin
        sweep_q <= sweep_d;
      end
      if (cmd_i.capture && (in_data_i.opcode == isingmp_pkg::OP_SET_SPIN)) begin
        spin_q[in_data_i.site_index] <= !in_data_i.coefficient[15];
      end
      if (cmd_i.decide && in_range && keep) begin
        spin_q[site_q] <= new_spin;
      end
      if (cmd_i.step_start) begin
        idx_q <= '0;
      end else if (cmd_i.sum_issue) begin
        idx_q <= idx_q + SiteW'(1);
      end
    end
  end

  // Field memory.
  assign field_we = cmd_i.capture && (in_data_i.opcode == isingmp_pkg::OP_LOAD_FIELD);

  always_ff @(posedge clk_i) begin
    if (field_we) begin
      field_mem[in_data_i.site_index] <= in_data_i.coefficient;
    end
    field_rd_q <= field_mem[site_q];
  end

  // Coupling memory: the pair is written as the direct entry on capture, then mirrored.
  assign coup_we = (cmd_i.capture && (in_data_i.opcode == isingmp_pkg::OP_LOAD_COUPLING))
                   || cmd_i.couple2;
  assign coup_waddr = cmd_i.couple2 ? {partner_q, site_q}
                                    : {in_data_i.site_index, in_data_i.partner_index};
  assign coup_wdata = cmd_i.couple2 ? coef_q : in_data_i.coefficient;

  always_ff @(posedge clk_i) begin
    if (coup_we) begin
      coup_mem[coup_waddr] <= coup_wdata;
    end
    coup_rd_q <= coup_mem[{site_q, idx_q}];
  end

  // Local field accumulation: the field first, then one coupling per cycle,
  // signed by the neighbor spin and skipping the site itself.
  assign fld_ext = AccW'(field_rd_q);

  always_comb begin
    term = AccW'(coup_rd_q);
    if (!spin_q[rd_idx_q]) begin
      term = -term;
    end
    if (rd_idx_q == site_q) begin
      term = '0;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.step_start) begin
      acc_d = '0;
    end else if (fld_vld_q) begin
      acc_d = acc_q + fld_ext;
    end else if (rd_vld_q) begin
      acc_d = acc_q + term;
    end
  end

  assign acc2 = {acc_q, 1'b0};

  // Item, energy and result registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.capture) begin
      site_q     <= (cap_step && sys_mode_q) ? cur_site : in_data_i.site_index;
      partner_q  <= in_data_i.partner_index;
      coef_q     <= in_data_i.coefficient;
      draw_q     <= in_data_i.uniform_draw;
      acc_flag_q <= 1'b0;
      de_res_q   <= '0;
    end
    if (cmd_i.de_calc) begin
      de_q <= new_spin ? -acc2 : acc2;
    end
    if (cmd_i.exp_read) begin
      if (de_q[DeW-1:ExpW+2] == '0) begin
        exp_q <= isingmp_pkg::EXP_ROM[de_q[ExpW+1:2]];
      end else begin
        exp_q <= '0;
      end
    end
    if (cmd_i.decide && in_range && keep) begin
      acc_flag_q <= 1'b1;
      de_res_q   <= de_q;
    end
    if (cmd_i.load_out) begin
      out_q.site          <= site_q;
      out_q.spin_up       <= spin_q[site_q];
      out_q.accepted      <= acc_flag_q;
      out_q.energy_change <= de_res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire
